@@ rtl/core/dbd_pkg.sv @@
package dbd_pkg;

    localparam int DIGIT_COUNT = 6;
    localparam int DIGIT_W     = 4;
    localparam int CURSOR_W    = $clog2(DIGIT_COUNT);
    localparam int TIMER_W     = 16;
    localparam int WEIGHT_W    = 17;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    typedef logic [DIGIT_W-1:0]                    digit_t;
    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   digit_row_t;
    typedef logic [CURSOR_W-1:0]                   cursor_t;
    typedef logic [DIGIT_COUNT-1:0]                mask_t;
    typedef logic [TIMER_W-1:0]                    timer_t;
    typedef logic [WEIGHT_W-1:0]                   weight_t;

    // register map, byte address 4*index
    typedef enum logic [1:0] {
        REG_BLINK_PERIOD,
        REG_TICK_STEP,
        REG_BLANK_CODE,
        REG_SCALE_MAX
    } reg_idx_t;

    typedef struct packed {
        timer_t blink_period;
        timer_t tick_step;
        digit_t blank_code;
        digit_t scale_max;
    } cfg_t;

    typedef struct packed {
        logic start_edit;
        logic next_position;
        logic increase;
        logic decrease;
        logic done_ok;
        logic done_fail;
    } events_t;

    typedef struct packed {
        digit_row_t digits;
        digit_row_t shown;
        cursor_t    cursor;
        mask_t      mask;
        timer_t     elapsed;
    } edit_state_t;

    localparam cfg_t CFG_RESET = '{
        blink_period: 16'd500,
        tick_step:    16'd50,
        blank_code:   4'd15,
        scale_max:    4'd4
    };

    localparam edit_state_t STATE_RESET = '{
        digits:  (DIGIT_COUNT*DIGIT_W)'(1),
        shown:   '0,
        cursor:  '0,
        mask:    '0,
        elapsed: '0
    };

    localparam cursor_t LAST_POS    = CURSOR_W'(DIGIT_COUNT - 1);
    localparam digit_t  DECIMAL_MAX = 4'd9;
    localparam digit_t  SCALE_MIN   = 4'd1;

    localparam weight_t WEIGHT_10K = 17'd10000;
    localparam weight_t WEIGHT_1K  = 17'd1000;
    localparam weight_t WEIGHT_100 = 17'd100;
    localparam weight_t WEIGHT_10  = 17'd10;

endpackage

@@ rtl/core/dbd_in_if.sv @@
interface dbd_in_if;
    logic valid;
    logic ready;
    logic start_edit;
    logic next_position;
    logic increase;
    logic decrease;
    logic done_ok;
    logic done_fail;

    modport source (
        output valid, start_edit, next_position, increase, decrease, done_ok, done_fail,
        input  ready
    );
    modport sink (
        input  valid, start_edit, next_position, increase, decrease, done_ok, done_fail,
        output ready
    );
endinterface

@@ rtl/core/dbd_out_if.sv @@
interface dbd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  shown_0;
    logic [3:0]  shown_1;
    logic [3:0]  shown_2;
    logic [3:0]  shown_3;
    logic [3:0]  shown_4;
    logic [3:0]  shown_5;
    logic [3:0]  scale_number;
    logic [16:0] entered_weight;

    modport source (
        output valid, shown_0, shown_1, shown_2, shown_3, shown_4, shown_5,
               scale_number, entered_weight,
        input  ready
    );
    modport sink (
        input  valid, shown_0, shown_1, shown_2, shown_3, shown_4, shown_5,
               scale_number, entered_weight,
        output ready
    );
endinterface

@@ rtl/core/digit_entry_blink_display_top.sv @@
// channel  dir  modport  payload
// in_ch    in   sink     start_edit next_position increase decrease done_ok done_fail
// out_ch   out  source   shown_0..shown_5 scale_number entered_weight
// apb      in   slave    four registers at byte addresses 0, 4, 8, 12
//
// one word accepted per cycle unless out_ch stalls; a taken word goes into the
// event register, then through the edit logic into the state and result registers
// rst_n clears state asynchronously: scale 1, digits 0, no blink, timer 0
// a stall on out_ch holds the result register; in_ch keeps accepting until the
// event register is also full, so a stall costs no throughput once released
module digit_entry_blink_display_top (
    input  logic                           clk,
    input  logic                           rst_n,
    dbd_in_if.sink                         in_ch,
    dbd_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dbd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dbd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    dbd_pkg::cfg_t        cfg;
    dbd_pkg::edit_state_t state_reg;
    dbd_pkg::edit_state_t state_next;
    dbd_pkg::events_t     ev_reg;
    dbd_pkg::weight_t     weight_next;
    dbd_pkg::digit_row_t  shown_out_reg;
    dbd_pkg::digit_t      scale_out_reg;
    dbd_pkg::weight_t     weight_out_reg;
    logic                 ev_vld_reg;
    logic                 out_vld_reg;
    logic                 advance;
    logic                 in_take;

    // configuration registers, zero wait states
    assign pready = 1'b1;

    dbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // handshake: the event word moves on when the result register is free
    assign advance     = ev_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready = !ev_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= dbd_pkg::STATE_RESET;
        end
        else
        begin
            if (in_ch.ready)
            begin
                ev_vld_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // event word capture
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg.start_edit    <= in_ch.start_edit;
            ev_reg.next_position <= in_ch.next_position;
            ev_reg.increase      <= in_ch.increase;
            ev_reg.decrease      <= in_ch.decrease;
            ev_reg.done_ok       <= in_ch.done_ok;
            ev_reg.done_fail     <= in_ch.done_fail;
        end
    end

    // edit logic: events in fixed order, then blink refresh and timer
    dbd_step u_step (
        .cur (state_reg),
        .ev  (ev_reg),
        .cfg (cfg),
        .nxt (state_next)
    );

    // decimal weight of positions one to five
    dbd_weight u_weight (
        .digits (state_next.digits),
        .weight (weight_next)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shown_out_reg  <= state_next.shown;
            scale_out_reg  <= state_next.digits[0];
            weight_out_reg <= weight_next;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.shown_0        = shown_out_reg[0];
    assign out_ch.shown_1        = shown_out_reg[1];
    assign out_ch.shown_2        = shown_out_reg[2];
    assign out_ch.shown_3        = shown_out_reg[3];
    assign out_ch.shown_4        = shown_out_reg[4];
    assign out_ch.shown_5        = shown_out_reg[5];
    assign out_ch.scale_number   = scale_out_reg;
    assign out_ch.entered_weight = weight_out_reg;

    // cursor never leaves the display
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cursor <= dbd_pkg::LAST_POS)
        else $error("cursor out of range");

    // timer only runs while something blinks
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mask == '0) |-> (state_reg.elapsed == '0))
        else $error("blink timer running with no blink");

    // blink is off, the cursor digit alone, or everything after a failure
    a_mask_shape: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(state_reg.mask) || (state_reg.mask == '1))
        else $error("unexpected blink mask");

    // scale never zero, decimal digits stay decimal
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.digits[0] != '0) &&
        (state_reg.digits[1] <= dbd_pkg::DECIMAL_MAX) &&
        (state_reg.digits[2] <= dbd_pkg::DECIMAL_MAX) &&
        (state_reg.digits[3] <= dbd_pkg::DECIMAL_MAX) &&
        (state_reg.digits[4] <= dbd_pkg::DECIMAL_MAX) &&
        (state_reg.digits[5] <= dbd_pkg::DECIMAL_MAX))
        else $error("digit value out of range");

endmodule

@@ rtl/core/dbd_cfg.sv @@
module dbd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dbd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dbd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dbd_pkg::APB_DATA_W-1:0]     prdata,
    output dbd_pkg::cfg_t                      cfg
);

    dbd_pkg::cfg_t     cfg_reg;
    dbd_pkg::reg_idx_t sel_idx;
    logic              wr_en;

    assign sel_idx = dbd_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dbd_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel_idx)
                dbd_pkg::REG_BLINK_PERIOD: cfg_reg.blink_period <= pwdata[15:0];
                dbd_pkg::REG_TICK_STEP:    cfg_reg.tick_step    <= pwdata[15:0];
                dbd_pkg::REG_BLANK_CODE:   cfg_reg.blank_code   <= pwdata[3:0];
                dbd_pkg::REG_SCALE_MAX:    cfg_reg.scale_max    <= pwdata[3:0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel_idx)
            dbd_pkg::REG_BLINK_PERIOD: prdata = 32'(cfg_reg.blink_period);
            dbd_pkg::REG_TICK_STEP:    prdata = 32'(cfg_reg.tick_step);
            dbd_pkg::REG_BLANK_CODE:   prdata = 32'(cfg_reg.blank_code);
            dbd_pkg::REG_SCALE_MAX:    prdata = 32'(cfg_reg.scale_max);
            default:                   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/dbd_step.sv @@
module dbd_step (
    input  dbd_pkg::edit_state_t cur,
    input  dbd_pkg::events_t     ev,
    input  dbd_pkg::cfg_t        cfg,
    output dbd_pkg::edit_state_t nxt
);

    dbd_pkg::cursor_t    cur_a;
    dbd_pkg::cursor_t    cur_b;
    dbd_pkg::mask_t      mask_a;
    dbd_pkg::mask_t      mask_b;
    dbd_pkg::timer_t     tmr_a;
    dbd_pkg::timer_t     tmr_b;
    dbd_pkg::timer_t     tmr_c;
    dbd_pkg::digit_t     val_cur;
    dbd_pkg::digit_t     val_inc;
    dbd_pkg::digit_t     val_dec;
    dbd_pkg::digit_t     lim_lo;
    dbd_pkg::digit_t     lim_hi;
    dbd_pkg::digit_row_t dig_new;
    dbd_pkg::digit_row_t shown_a;
    dbd_pkg::digit_row_t shown_new;
    logic                toggle;
    logic [dbd_pkg::TIMER_W:0] tmr_sum;

    // cursor moves: start, then next
    always_comb
    begin
        cur_a  = cur.cursor;
        mask_a = cur.mask;
        tmr_a  = cur.elapsed;
        if (ev.start_edit)
        begin
            cur_a  = '0;
            mask_a = dbd_pkg::mask_t'(1);
            tmr_a  = '0;
        end
        cur_b  = cur_a;
        mask_b = mask_a;
        tmr_b  = tmr_a;
        if (ev.next_position)
        begin
            cur_b  = (cur_a >= dbd_pkg::LAST_POS) ? '0 : cur_a + 1'b1;
            mask_b = dbd_pkg::mask_t'(1) << cur_b;
            tmr_b  = '0;
        end
    end

    // value edit under cursor
    always_comb
    begin
        val_cur = cur.digits[cur_b];
        if (cur_b == '0)
        begin
            lim_lo = dbd_pkg::SCALE_MIN;
            lim_hi = (cfg.scale_max == '0) ? dbd_pkg::SCALE_MIN : cfg.scale_max;
        end
        else
        begin
            lim_lo = '0;
            lim_hi = dbd_pkg::DECIMAL_MAX;
        end
        val_inc = val_cur;
        if (ev.increase)
        begin
            val_inc = (val_cur >= lim_hi) ? lim_lo : val_cur + 1'b1;
        end
        val_dec = val_inc;
        if (ev.decrease)
        begin
            val_dec = (val_inc <= lim_lo) ? lim_hi : val_inc - 1'b1;
        end
        dig_new        = cur.digits;
        dig_new[cur_b] = val_dec;
    end

    // ok / fail, then display refresh and blink timer
    always_comb
    begin
        nxt.cursor = cur_b;
        nxt.mask   = mask_b;
        tmr_c      = tmr_b;
        shown_a    = cur.shown;
        if (ev.done_ok)
        begin
            nxt.mask = '0;
            tmr_c    = '0;
        end
        if (ev.done_fail)
        begin
            shown_a[cur_b] = val_dec;
            nxt.mask       = '1;
            tmr_c          = '0;
        end

        toggle = (tmr_c >= cfg.blink_period);
        for (int i = 0; i < dbd_pkg::DIGIT_COUNT; i++)
        begin
            if (nxt.mask[i])
            begin
                if (toggle)
                begin
                    shown_new[i] = (shown_a[i] == cfg.blank_code) ? dig_new[i]
                                                                  : cfg.blank_code;
                end
                else
                begin
                    shown_new[i] = shown_a[i];
                end
            end
            else
            begin
                shown_new[i] = dig_new[i];
            end
        end

        tmr_sum = {1'b0, (toggle ? dbd_pkg::timer_t'(0) : tmr_c)} + {1'b0, cfg.tick_step};
        if (nxt.mask == '0)
        begin
            nxt.elapsed = toggle ? '0 : tmr_c;
        end
        else
        begin
            nxt.elapsed = tmr_sum[dbd_pkg::TIMER_W] ? '1 : tmr_sum[dbd_pkg::TIMER_W-1:0];
        end
        nxt.digits = dig_new;
        nxt.shown  = shown_new;
    end

endmodule

@@ rtl/core/dbd_weight.sv @@
module dbd_weight (
    input  dbd_pkg::digit_row_t digits,
    output dbd_pkg::weight_t    weight
);

    // constant multiplies reduce to shift-add trees
    assign weight = dbd_pkg::weight_t'(digits[1]) * dbd_pkg::WEIGHT_10K
                  + dbd_pkg::weight_t'(digits[2]) * dbd_pkg::WEIGHT_1K
                  + dbd_pkg::weight_t'(digits[3]) * dbd_pkg::WEIGHT_100
                  + dbd_pkg::weight_t'(digits[4]) * dbd_pkg::WEIGHT_10
                  + dbd_pkg::weight_t'(digits[5]);

endmodule

@@ bench/digit_entry_blink_display_checker.sv @@
module digit_entry_blink_display_checker
    import dbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dbd_in_if                     in_ch,
    dbd_out_if                    out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        digit_row_t shown;
        digit_t     scale;
        weight_t    weight;
    } panel_word_t;

    cfg_t        cfg;
    digit_row_t  digits;
    digit_row_t  shown;
    cursor_t     cursor;
    mask_t       mask;
    timer_t      elapsed;
    panel_word_t panel_queue[$];

    function automatic digit_t floor_of(cursor_t pos);
        return (pos == 0) ? digit_t'(1) : digit_t'(0);
    endfunction

    function automatic digit_t ceiling_of(cursor_t pos);
        if (pos != 0)
            return digit_t'(9);
        return (cfg.scale_max == 0) ? digit_t'(1) : cfg.scale_max;
    endfunction

    // one loop pass of the panel editor
    function automatic panel_word_t step_panel(events_t ev);
        logic              roll;
        logic [TIMER_W:0]  sum;
        cursor_t           c;
        panel_word_t       w;
        if (ev.start_edit)
        begin
            cursor  = '0;
            mask    = mask_t'(1);
            elapsed = '0;
        end
        if (ev.next_position)
        begin
            cursor  = (cursor >= cursor_t'(DIGIT_COUNT - 1)) ? cursor_t'(0) : cursor + 1'b1;
            mask    = mask_t'(1) << cursor;
            elapsed = '0;
        end
        c = cursor;
        if (ev.increase)
            digits[c] = (digits[c] >= ceiling_of(c)) ? floor_of(c) : digits[c] + 1'b1;
        if (ev.decrease)
            digits[c] = (digits[c] <= floor_of(c)) ? ceiling_of(c) : digits[c] - 1'b1;
        if (ev.done_ok)
        begin
            mask    = '0;
            elapsed = '0;
        end
        if (ev.done_fail)
        begin
            shown[c] = digits[c];
            mask     = '1;
            elapsed  = '0;
        end
        roll = (elapsed >= cfg.blink_period);
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (!mask[i])
                shown[i] = digits[i];
            else if (roll)
                shown[i] = (shown[i] == cfg.blank_code) ? digits[i] : cfg.blank_code;
        end
        if (roll)
            elapsed = '0;
        if (mask != '0)
        begin
            sum     = {1'b0, elapsed} + cfg.tick_step;
            elapsed = sum[TIMER_W] ? '1 : sum[TIMER_W-1:0];
        end
        w.shown  = shown;
        w.scale  = digits[0];
        w.weight = weight_t'(digits[1]) * 17'd10000 + weight_t'(digits[2]) * 17'd1000
                 + weight_t'(digits[3]) * 17'd100 + weight_t'(digits[4]) * 17'd10
                 + weight_t'(digits[5]);
        return w;
    endfunction

    task automatic check_panel_word();
        panel_word_t want;
        digit_row_t  got_shown;
        if (panel_queue.size() == 0)
        begin
            $error("display word with no expected word waiting");
            fail_count++;
            return;
        end
        want      = panel_queue.pop_front();
        got_shown = {out_ch.shown_5, out_ch.shown_4, out_ch.shown_3,
                     out_ch.shown_2, out_ch.shown_1, out_ch.shown_0};
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (got_shown[i] !== want.shown[i])
            begin
                $error("shown_%0d expected %0d got %0d", i, want.shown[i], got_shown[i]);
                fail_count++;
            end
        end
        if (out_ch.scale_number !== want.scale)
        begin
            $error("scale_number expected %0d got %0d", want.scale, out_ch.scale_number);
            fail_count++;
        end
        if (out_ch.entered_weight !== want.weight)
        begin
            $error("entered_weight expected %0d got %0d", want.weight, out_ch.entered_weight);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.blink_period = 16'd500;
            cfg.tick_step    = 16'd50;
            cfg.blank_code   = 4'd15;
            cfg.scale_max    = 4'd4;
            digits           = '0;
            digits[0]        = digit_t'(1);
            shown            = '0;
            cursor           = '0;
            mask             = '0;
            elapsed          = '0;
            panel_queue.delete();
            pending          = 0;
        end
        else
        begin
            // a word leaving now was taken earlier, so its prediction is already queued
            if (out_ch.valid && out_ch.ready)
                check_panel_word();
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_BLINK_PERIOD: cfg.blink_period = pwdata[TIMER_W-1:0];
                    REG_TICK_STEP:    cfg.tick_step    = pwdata[TIMER_W-1:0];
                    REG_BLANK_CODE:   cfg.blank_code   = pwdata[DIGIT_W-1:0];
                    REG_SCALE_MAX:    cfg.scale_max    = pwdata[DIGIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                panel_queue.push_back(step_panel({in_ch.start_edit, in_ch.next_position,
                                                  in_ch.increase, in_ch.decrease,
                                                  in_ch.done_ok, in_ch.done_fail}));
            pending = panel_queue.size();
        end
    end

endmodule

@@ bench/digit_entry_blink_display_top_test.sv @@
module digit_entry_blink_display_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dbd_pkg::*;

    // single-flag event words, combined by or where needed
    localparam events_t EV_TICK  = '0;
    localparam events_t EV_START = '{start_edit: 1'b1, default: 1'b0};
    localparam events_t EV_NEXT  = '{next_position: 1'b1, default: 1'b0};
    localparam events_t EV_INC   = '{increase: 1'b1, default: 1'b0};
    localparam events_t EV_DEC   = '{decrease: 1'b1, default: 1'b0};
    localparam events_t EV_OK    = '{done_ok: 1'b1, default: 1'b0};
    localparam events_t EV_FAIL  = '{done_fail: 1'b1, default: 1'b0};
    localparam events_t EV_ALL   = '1;

    localparam int WORDS_PER_PHASE = 80;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    words_pending;

    int       sent_words = 0;
    int       burst_left = 0;
    int       rx_left    = 0;
    rx_mode_e rx_mode    = RX_OPEN;
    cfg_t     settings[$];

    // walk every position, both wraps at each end, every flag, and the pile-ups
    events_t directed_words[$] = '{
        EV_TICK, EV_START, EV_DEC, EV_INC, EV_INC,
        EV_NEXT, EV_DEC, EV_INC, events_t'(EV_INC | EV_DEC),
        events_t'(EV_NEXT | EV_INC), EV_NEXT, events_t'(EV_NEXT | EV_INC),
        events_t'(EV_NEXT | EV_DEC), EV_NEXT,
        EV_FAIL, EV_TICK, EV_TICK, EV_TICK, EV_OK, EV_ALL,
        events_t'(EV_START | EV_NEXT), events_t'(EV_OK | EV_FAIL), EV_TICK
    };

    dbd_in_if  in_ch();
    dbd_out_if out_ch();

    digit_entry_blink_display_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // prediction and comparison live in the checker, the top only drives
    digit_entry_blink_display_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: mode changes at random, from always open to rare pulses
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   out_ch.ready <= 1'b1;
            RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= (rx_left % 12 == 0);
        endcase
    end

    // present one word, hold it until taken, then maybe close the burst
    task automatic send_word(input events_t ev);
        int gap;
        @(negedge clk);
        in_ch.valid <= 1'b1;
        {in_ch.start_edit, in_ch.next_position, in_ch.increase,
         in_ch.decrease, in_ch.done_ok, in_ch.done_fail} <= ev;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_words++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            // one burst in four is a long unbroken stretch
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // stop sending and wait for every predicted word to come out
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper data bits carry junk, the block keeps only the register width
    task automatic apply_config(input cfg_t c);
        write_reg(REG_BLINK_PERIOD, {16'($urandom), c.blink_period});
        write_reg(REG_TICK_STEP,    {16'($urandom), c.tick_step});
        write_reg(REG_BLANK_CODE,   {28'($urandom), c.blank_code});
        write_reg(REG_SCALE_MAX,    {28'($urandom), c.scale_max});
    endtask

    // a well-formed edit: start, a run of moves and steps, then ok or fail and idle ticks
    task automatic run_session();
        int steps;
        steps = $urandom_range(2, 16);
        send_word(EV_START);
        repeat (steps)
        begin
            case ($urandom_range(0, 9))
                0, 1:    send_word(EV_NEXT);
                2, 3:    send_word(EV_INC);
                4:       send_word(EV_DEC);
                5:       send_word(events_t'(EV_NEXT | EV_INC));
                default: send_word(EV_TICK);
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            send_word(EV_FAIL);
        else
            send_word(EV_OK);
        repeat ($urandom_range(0, 12))
            send_word(EV_TICK);
    endtask

    // noise and broken sequences: any mix of flags
    task automatic run_noise();
        events_t junk;
        repeat ($urandom_range(1, 6))
        begin
            junk = 6'($urandom_range(0, 63));
            send_word(junk);
        end
    endtask

    initial
    begin
        cfg_t rand_cfg;
        int   phase_end;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        {in_ch.start_edit, in_ch.next_position, in_ch.increase,
         in_ch.decrease, in_ch.done_ok, in_ch.done_fail} = EV_TICK;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        // settings after the reset values: tiny period, zero period, saturating timer
        // with zero scale max, a step far above the period, stuck timer, then random ones
        settings.push_back(cfg_t'{16'd3, 16'd1, 4'd0, 4'd1});
        settings.push_back(cfg_t'{16'd0, 16'd7, 4'd9, 4'd15});
        settings.push_back(cfg_t'{16'd65535, 16'd65535, 4'd15, 4'd0});
        settings.push_back(cfg_t'{16'd200, 16'd40000, 4'd5, 4'd2});
        settings.push_back(cfg_t'{16'd1, 16'd0, 4'd3, 4'd9});
        repeat (2)
        begin
            rand_cfg.blink_period = 16'($urandom_range(1, 2000));
            rand_cfg.tick_step    = 16'($urandom_range(1, 400));
            rand_cfg.blank_code   = 4'($urandom_range(0, 15));
            rand_cfg.scale_max    = 4'($urandom_range(0, 15));
            settings.push_back(rand_cfg);
        end

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words under the reset register values
        foreach (directed_words[i])
            send_word(directed_words[i]);

        // first random phase on reset values, then one phase per setting;
        // each change waits for the pipe to empty first
        for (int p = 0; p <= settings.size(); p++)
        begin
            if (p > 0)
            begin
                drain();
                apply_config(settings[p-1]);
            end
            phase_end = sent_words + WORDS_PER_PHASE;
            while (sent_words < phase_end)
            begin
                if ($urandom_range(0, 4) == 0)
                    run_noise();
                else
                    run_session();
            end
        end

        drain();
        // wait for a stray word behind the last one
        repeat (6)
            @(negedge clk);
        if (fail_count == 0)
            $display("digit_entry_blink_display_top_test OK");
        else
            $display("digit_entry_blink_display_top_test NOT OK");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("digit_entry_blink_display_top_test NOT OK");
        $finish;
    end

endmodule
